// ===== hdl/ps2md_pkg.sv =====
package ps2md_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    localparam int LEN_WIDTH   = 3;
    localparam int BYTE_WIDTH  = 8;
    localparam int MOVE_WIDTH  = 9;
    localparam int WHEEL_WIDTH = 5;
    localparam int BTN_WIDTH   = 3;
    localparam int SEEN_WIDTH  = 32;

    // Bit positions inside the first byte of a packet.
    localparam int SYNC_BIT    = 3;
    localparam int X_SIGN_BIT  = 4;
    localparam int Y_SIGN_BIT  = 5;
    localparam int X_OVF_BIT   = 6;
    localparam int Y_OVF_BIT   = 7;

    localparam logic [LEN_WIDTH-1:0] LEN_PLAIN = 3'd3;

    localparam int S_TDATA_WIDTH = 8;
    localparam int M_TDATA_WIDTH = 64;

    typedef struct packed {
        logic                          event_valid;
        logic signed [MOVE_WIDTH-1:0]  move_x;
        logic signed [MOVE_WIDTH-1:0]  move_y;
        logic signed [WHEEL_WIDTH-1:0] wheel;
        logic [BTN_WIDTH-1:0]          buttons;
        logic [SEEN_WIDTH-1:0]         packets_seen;
    } t_result;

endpackage

// ===== hdl/ps2md_assembler.sv =====
module ps2md_assembler
    import ps2md_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic                  i_byte_ready,
    input  logic                  i_from_aux,
    input  logic [BYTE_WIDTH-1:0] i_data_byte,
    input  logic                  i_len_four,
    output t_result               o_result
);

    logic [BYTE_WIDTH-1:0]  r_byte0, r_byte1, r_byte2;
    logic [BYTE_WIDTH-1:0]  n_byte0, n_byte1, n_byte2;
    logic [1:0]             r_pos, n_pos;
    logic [COUNT_WIDTH-1:0] r_count, n_count;

    logic                  gather;
    logic                  complete;
    logic [2:0]            pos_inc;
    logic [2:0]            len;
    logic [BYTE_WIDTH-1:0] flags, byte1, byte2;
    logic [3:0]            nibble;
    logic [WHEEL_WIDTH-1:0] wheel_raw;
    logic [SEEN_WIDTH-1:0] seen;

    // A byte counts only when present, from the mouse port, and, at the start
    // of a packet, carrying the sync bit.
    assign gather   = i_byte_ready && i_from_aux &&
                      !(r_pos == 2'd0 && !i_data_byte[SYNC_BIT]);
    assign len      = i_len_four ? 3'd4 : 3'd3;
    assign pos_inc  = {1'b0, r_pos} + 3'd1;
    assign complete = gather && (pos_inc >= len);

    // The first byte can never complete a packet, so flags are always stored.
    assign flags  = r_byte0;
    assign byte1  = (r_pos == 2'd1) ? i_data_byte : r_byte1;
    assign byte2  = (r_pos == 2'd2) ? i_data_byte : r_byte2;
    assign nibble = i_data_byte[3:0];
    assign wheel_raw = {nibble[3], nibble};

    always_comb begin
        n_byte0 = r_byte0;
        n_byte1 = r_byte1;
        n_byte2 = r_byte2;
        n_pos   = r_pos;
        n_count = r_count;
        if (gather) begin
            case (r_pos)
                2'd0:    n_byte0 = i_data_byte;
                2'd1:    n_byte1 = i_data_byte;
                2'd2:    n_byte2 = i_data_byte;
                default: ;
            endcase
            if (complete) begin
                n_pos   = 2'd0;
                n_count = r_count + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
            end else begin
                n_pos = pos_inc[1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte0 <= '0;
            r_byte1 <= '0;
            r_byte2 <= '0;
            r_pos   <= '0;
            r_count <= '0;
        end else if (i_take) begin
            r_byte0 <= n_byte0;
            r_byte1 <= n_byte1;
            r_byte2 <= n_byte2;
            r_pos   <= n_pos;
            r_count <= n_count;
        end
    end

    generate
        if (COUNT_WIDTH >= SEEN_WIDTH) begin : g_seen_trunc
            assign seen = n_count[SEEN_WIDTH-1:0];
        end else begin : g_seen_ext
            assign seen = {{(SEEN_WIDTH-COUNT_WIDTH){1'b0}}, n_count};
        end
    endgenerate

    always_comb begin
        o_result              = '0;
        o_result.packets_seen = seen;
        if (complete && !flags[X_OVF_BIT] && !flags[Y_OVF_BIT]) begin
            o_result.event_valid = 1'b1;
            o_result.move_x      = {flags[X_SIGN_BIT], byte1};
            o_result.move_y      = {flags[Y_SIGN_BIT], byte2};
            o_result.wheel       = i_len_four ? (WHEEL_WIDTH'(0) - wheel_raw) : '0;
            o_result.buttons     = flags[BTN_WIDTH-1:0];
        end
    end

endmodule

// ===== hdl/ps2_mouse_packet_decoder.sv =====
// PS/2 mouse packet decoder. Each input item is one controller status/data
// pair; each item gives exactly one output item in the cycle after it is taken,
// and a new item is taken every cycle unless the output is stalled (one
// output register decouples the two sides). Bytes that are not ready or not
// from the aux port are ignored, and a first byte without bit 3 set is dropped
// to resynchronize. A packet is 3 bytes, or 4 when the length register holds 4
// or more; tuser on the output flags an item that completed a packet without
// overflow, and then carries movement, wheel (negated, up positive) and
// buttons. packets_seen counts all completed packets and is on every item.
// Write the length register only while no item is in flight.
module ps2_mouse_packet_decoder
    import ps2md_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [LEN_WIDTH-1:0]     i_cfg_wr_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // data_byte[7:0]
    input  logic [S_TDATA_WIDTH-1:0] s_axis_tdata,
    // byte_ready[0], from_aux[1]
    input  logic [1:0]               s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // move_x[8:0], move_y[17:9], wheel[22:18], buttons[25:23],
    // packets_seen[57:26], zero[63:58]
    output logic [M_TDATA_WIDTH-1:0] m_axis_tdata,
    // event_valid[0]
    output logic                     m_axis_tuser
);

    logic [LEN_WIDTH-1:0] r_len;
    logic                 r_out_valid;
    t_result              r_out;
    t_result              result;
    logic                 take;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_PLAIN;
        end else if (i_cfg_wr_en) begin
            r_len <= i_cfg_wr_data;
        end
    end

    ps2md_assembler #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_assembler (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_byte_ready (s_axis_tuser[0]),
        .i_from_aux   (s_axis_tuser[1]),
        .i_data_byte  (s_axis_tdata),
        .i_len_four   (r_len[LEN_WIDTH-1]),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.event_valid;
    assign m_axis_tdata  = {6'd0, r_out.packets_seen, r_out.buttons, r_out.wheel,
                            r_out.move_y, r_out.move_x};

endmodule
